>>> src/digital_downconverter_decimating_defines.svh
// ----------------------------------------------------------------------------
// digital downconverter assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DIGITAL_DOWNCONVERTER_DECIMATING_DEFINES_SVH
`define DIGITAL_DOWNCONVERTER_DECIMATING_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DDC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DDC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define DDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// shared constants, types, filter coefficients and trig table builder
// ----------------------------------------------------------------------------
package ddc_pkg;

   localparam int TAP_COUNT       = 63;
   localparam int DECIMATION      = 8;
   localparam int DEC_BITS        = $clog2(DECIMATION);
   localparam int TABLE_SIZE      = 1024;
   localparam int TABLE_BITS      = $clog2(TABLE_SIZE);
   localparam int PHASE_WIDTH     = 32;
   localparam int PHASE_SHIFT     = PHASE_WIDTH - TABLE_BITS;
   localparam int RF_WIDTH        = 16;
   localparam int SAMPLE_WIDTH    = 24;
   localparam int GAIN_WIDTH      = 16;
   localparam int BLOCK_LEN_WIDTH = 17;
   localparam int COUNT_WIDTH     = BLOCK_LEN_WIDTH - DEC_BITS;
   localparam int COEF_WIDTH      = 18;
   localparam int TRIG_WIDTH      = 18;
   localparam int MIX_FRAC        = 8;
   localparam int COEF_FRAC       = 16;
   localparam int GAIN_FRAC       = 8;
   localparam int MIX_PROD_WIDTH  = RF_WIDTH + TRIG_WIDTH;
   localparam int TAP_PROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int GAIN_PROD_WIDTH = SAMPLE_WIDTH + GAIN_WIDTH;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [PHASE_WIDTH-1:0]     FREQ_WORD_RESET = '0;
   localparam logic [GAIN_WIDTH-1:0]      GAIN_RESET      = 16'h0100;
   localparam logic [BLOCK_LEN_WIDTH-1:0] BLOCK_LEN_RESET = 17'h10000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FREQ_WORD    = 2'd0,
      CSR_OUTPUT_GAIN  = 2'd1,
      CSR_BLOCK_LENGTH = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [TRIG_WIDTH-1:0]   trig_value_type;
   typedef trig_value_type                 trig_table_type [TABLE_SIZE];

   typedef struct packed {
      sample_type i;
      sample_type q;
   } iq_type;

   typedef struct packed {
      logic mul_en;   // load tap products from the mixer word
      logic acc_en;   // fold products into the partial sums
   } cell_ctrl_type;

   // low-pass taps, Q2.16
   localparam coef_type FIR_COEF [TAP_COUNT] = '{
      -18'sd2674,   -18'sd3146,   -18'sd2360,   18'sd0,       18'sd4089,
      18'sd8971,    18'sd13533,   18'sd16685,   18'sd17314,   18'sd14791,
      18'sd9129,    18'sd943,     -18'sd8343,   -18'sd17315,  -18'sd24400,
      -18'sd28332,  -18'sd28017,  -18'sd22820,  -18'sd12911,  18'sd0,
      18'sd13533,   18'sd25657,   18'sd34000,   18'sd36831,   18'sd33370,
      18'sd23769,   18'sd8971,    -18'sd8343,   -18'sd25186,  -18'sd38883,
      -18'sd46905,  -18'sd47534,  -18'sd39512,  -18'sd23141,  18'sd0,
      18'sd26915,   18'sd53831,   18'sd77129,   18'sd93808,   18'sd101364,
      18'sd98526,   18'sd85622,   18'sd64697,   18'sd38561,   18'sd11337,
      -18'sd12911,  -18'sd30540,  -18'sd39198,  -18'sd38562,  -18'sd29590,
      -18'sd14792,  18'sd1887,    18'sd16685,   18'sd26915,   18'sd31168,
      18'sd28960,   18'sd21246,   18'sd10544,   18'sd0,       18'sd0,
      -18'sd8343,   18'sd0,       18'sd0
   };

   // angle constants in Q28
   localparam longint unsigned PI_Q28      = 64'd843314857;
   localparam longint unsigned TWO_PI_Q28  = 2 * PI_Q28;
   localparam longint unsigned HALF_PI_Q28 = PI_Q28 / 2;
   localparam longint unsigned TABLE_SIZE_L = longint'(TABLE_SIZE);

   // taylor series divisors (2n)(2n+1)
   localparam longint unsigned SERIES_DIV [1:9] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
   };

   // round(sin or cos(2*pi*idx/TABLE_SIZE) * 2^16), integer series in Q28
   function automatic trig_value_type trig_entry(input longint unsigned idx,
                                                 input logic cosine);
      longint unsigned th;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned r;
      longint          sum;
      logic            neg;
      trig_value_type  val;
      int              n;
      if (cosine) begin
         th = ((4 * idx + TABLE_SIZE_L) * TWO_PI_Q28 + 2 * TABLE_SIZE_L)
              / (4 * TABLE_SIZE_L);
      end else begin
         th = (idx * TWO_PI_Q28 + TABLE_SIZE_L / 2) / TABLE_SIZE_L;
      end
      th  = th % TWO_PI_Q28;
      neg = 1'b0;
      if (th >= PI_Q28) begin
         th  = th - PI_Q28;
         neg = 1'b1;
      end
      if (th > HALF_PI_Q28) begin
         th = PI_Q28 - th;
      end
      x2   = (th * th) >> 28;
      term = th;
      sum  = longint'(th);
      for (n = 1; n <= 9; n++) begin
         term = ((term * x2) >> 28) / SERIES_DIV[n];
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (longint'(sum) + 2048) >> 12;
      if (r > 64'd65536) begin
         r = 64'd65536;
      end
      val = trig_value_type'(r[TRIG_WIDTH-1:0]);
      if (neg) begin
         val = -val;
      end
      return val;
   endfunction

   function automatic trig_table_type build_trig_table(input logic cosine);
      trig_table_type t;
      int             k;
      for (k = 0; k < TABLE_SIZE; k++) begin
         t[k] = trig_entry(longint'(k), cosine);
      end
      return t;
   endfunction

endpackage

>>> src/ddc_if.sv
// ----------------------------------------------------------------------------
// ddc channel interfaces
// valid/ready channels for rf sample words and baseband result words
// ----------------------------------------------------------------------------
interface ddc_req_if;
   import ddc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [RF_WIDTH-1:0] rf_value;
   logic                       block_start;

   modport source (output valid, output rf_value, output block_start, input ready);
   modport sink   (input valid, input rf_value, input block_start, output ready);
endinterface

interface ddc_rsp_if;
   import ddc_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] i_sample;
   logic signed [SAMPLE_WIDTH-1:0] q_sample;

   modport source (output valid, output i_sample, output q_sample, input ready);
   modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

>>> src/ddc_trig_rom.sv
// ----------------------------------------------------------------------------
// ddc_trig_rom
// sine and cosine lookup, one table entry per phase index, registered read
// ----------------------------------------------------------------------------
module ddc_trig_rom (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [ddc_pkg::TABLE_BITS-1:0]   rd_addr,
   output ddc_pkg::trig_value_type          sin_val,
   output ddc_pkg::trig_value_type          cos_val
);
   import ddc_pkg::*;

   localparam trig_table_type SINE_ROM   = build_trig_table(1'b0);
   localparam trig_table_type COSINE_ROM = build_trig_table(1'b1);

   trig_value_type sin_ff;
   trig_value_type cos_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sin_ff <= SINE_ROM[rd_addr];
         cos_ff <= COSINE_ROM[rd_addr];
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

>>> src/ddc_fir_cell.sv
// ----------------------------------------------------------------------------
// ddc_fir_cell
// one tap of the transposed fir: product register and partial sum register
// ----------------------------------------------------------------------------
module ddc_fir_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ddc_pkg::cell_ctrl_type  ctrl,
   input  ddc_pkg::iq_type         mixed,
   input  ddc_pkg::coef_type       coef,
   input  ddc_pkg::iq_type         sum_in,
   output ddc_pkg::iq_type         sum_out
);
   import ddc_pkg::*;

   logic signed [TAP_PROD_WIDTH-1:0] prod_i;
   logic signed [TAP_PROD_WIDTH-1:0] prod_q;
   iq_type                           prod_ff;
   iq_type                           sum_ff;
   iq_type                           sum_in_next;

   assign prod_i = mixed.i * coef;
   assign prod_q = mixed.q * coef;

   // floor by 2^16, wrap to 24 bits
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff.i <= prod_i[COEF_FRAC +: SAMPLE_WIDTH];
         prod_ff.q <= prod_q[COEF_FRAC +: SAMPLE_WIDTH];
      end
   end

   always_comb begin
      sum_in_next.i = prod_ff.i + sum_in.i;
      sum_in_next.q = prod_ff.q + sum_in.q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.acc_en) begin
         sum_ff <= sum_in_next;
      end
   end

   assign sum_out = sum_ff;

endmodule

>>> src/digital_downconverter_decimating.sv
// ----------------------------------------------------------------------------
// digital_downconverter_decimating
// nco mixer, 63-tap transposed fir as a row of cells, decimate by 8, gain
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  req_chan  in         valid/ready               rf_value, block_start
//  rsp_chan  out        valid/ready               i_sample, q_sample
//  csr_*     in         csr_we, no back-pressure  csr_index, csr_wdata
//
//  one word accepted per clock while ready is high; the word at decimation
//  slot zero passes the rom read, mixer, tap products, partial sums and gain
//  stage registers into the output register, and the fir cells take a word
//  every cycle that the pipe advances; reset is synchronous; the trig tables
//  are constant; req_chan.ready drops only while a result-bearing word sits
//  in the gain stage and the output register is full and not being taken
// ----------------------------------------------------------------------------
`include "digital_downconverter_decimating_defines.svh"

module digital_downconverter_decimating (
   input  logic                                  clock,
   input  logic                                  reset,
   ddc_req_if.sink                               req_chan,
   ddc_rsp_if.source                             rsp_chan,
   input  logic                                  csr_we,
   input  logic [ddc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ddc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import ddc_pkg::*;

   // configuration registers
   logic [PHASE_WIDTH-1:0]        freq_word_ff;
   logic signed [GAIN_WIDTH-1:0]  gain_ff;
   logic [BLOCK_LEN_WIDTH-1:0]    block_len_ff;

   // nco and block bookkeeping
   logic [PHASE_WIDTH-1:0]        phase_ff;
   logic [PHASE_WIDTH-1:0]        phase_sum;
   logic [DEC_BITS-1:0]           dec_phase_ff;
   logic [DEC_BITS-1:0]           dec_phase_in;
   logic [DEC_BITS-1:0]           dec_phase_start;
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;
   logic [COUNT_WIDTH-1:0]        count_start;
   logic [COUNT_WIDTH-1:0]        out_cap;
   logic                          produce_in;

   // pipeline control
   logic                          accept;
   logic                          adv;

   // stage 1: rom read, sample held
   logic                          s1_valid_ff;
   logic                          s1_produce_ff;
   logic signed [RF_WIDTH-1:0]    s1_x_ff;
   trig_value_type                sin_val;
   trig_value_type                cos_val;
   trig_value_type                neg_sin;
   logic signed [MIX_PROD_WIDTH-1:0] mix_prod_i;
   logic signed [MIX_PROD_WIDTH-1:0] mix_prod_q;

   // stage 2: mixed word
   logic                          s2_valid_ff;
   logic                          s2_produce_ff;
   iq_type                        s2_mixed_ff;

   // stage 3: tap products in the cells
   logic                          p_valid_ff;
   logic                          p_produce_ff;

   // stage 4: partial sums in the cells
   logic                          s_valid_ff;
   logic                          s_produce_ff;
   cell_ctrl_type                 cell_ctrl;
   iq_type                        sum_chain [TAP_COUNT+1];

   // stage 5: gain
   logic                          g_valid_ff;
   logic                          g_produce_ff;
   logic signed [GAIN_PROD_WIDTH-1:0] gain_prod_i;
   logic signed [GAIN_PROD_WIDTH-1:0] gain_prod_q;
   iq_type                        g_out_ff;

   // output register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   iq_type                        rsp_data_ff;

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_word_ff <= FREQ_WORD_RESET;
         gain_ff      <= GAIN_RESET;
         block_len_ff <= BLOCK_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FREQ_WORD:    freq_word_ff <= csr_wdata[PHASE_WIDTH-1:0];
            CSR_OUTPUT_GAIN:  gain_ff      <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_BLOCK_LENGTH: block_len_ff <= csr_wdata[BLOCK_LEN_WIDTH-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // handshake: the whole pipe moves together unless a result would be lost
   // ---------------------------------------------------------------------
   assign adv            = !(g_valid_ff && g_produce_ff && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;

   // ---------------------------------------------------------------------
   // nco phase and decimation bookkeeping at acceptance
   // ---------------------------------------------------------------------
   assign phase_sum = phase_ff + freq_word_ff;
   assign out_cap   = block_len_ff[BLOCK_LEN_WIDTH-1:DEC_BITS];

   always_comb begin
      // block start clears phase and count before this word is handled
      dec_phase_start = req_chan.block_start ? '0 : dec_phase_ff;
      count_start     = req_chan.block_start ? '0 : count_ff;
      produce_in      = (dec_phase_start == '0) && (count_start < out_cap);
      count_in        = count_start + COUNT_WIDTH'(produce_in);
      dec_phase_in    = dec_phase_start + DEC_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         dec_phase_ff <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         phase_ff     <= phase_sum;
         dec_phase_ff <= dec_phase_in;
         count_ff     <= count_in;
      end
   end

   // top bits of the advanced phase address both tables
   ddc_trig_rom u_trig_rom (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (phase_sum[PHASE_WIDTH-1:PHASE_SHIFT]),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   // ---------------------------------------------------------------------
   // stage valid and produce flags
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
         s_valid_ff  <= 1'b0;
         g_valid_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         p_valid_ff  <= s2_valid_ff;
         s_valid_ff  <= p_valid_ff;
         g_valid_ff  <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_produce_ff <= produce_in;
         s1_x_ff       <= req_chan.rf_value;
         s2_produce_ff <= s1_produce_ff;
         p_produce_ff  <= s2_produce_ff;
         s_produce_ff  <= p_produce_ff;
         g_produce_ff  <= s_produce_ff;
      end
   end

   // ---------------------------------------------------------------------
   // mixer: i = x*cos, q = x*(-sin), floor by 2^8 and wrap to 24 bits
   // ---------------------------------------------------------------------
   assign neg_sin    = -sin_val;
   assign mix_prod_i = s1_x_ff * cos_val;
   assign mix_prod_q = s1_x_ff * neg_sin;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mixed_ff.i <= mix_prod_i[MIX_FRAC +: SAMPLE_WIDTH];
         s2_mixed_ff.q <= mix_prod_q[MIX_FRAC +: SAMPLE_WIDTH];
      end
   end

   // ---------------------------------------------------------------------
   // transposed fir: every cell sees the mixed word, partial sums run from
   // the last tap towards cell zero, one cell per word
   // ---------------------------------------------------------------------
   assign cell_ctrl.mul_en      = adv;
   assign cell_ctrl.acc_en      = adv && p_valid_ff;
   assign sum_chain[TAP_COUNT]  = '0;

   for (genvar j = 0; j < TAP_COUNT; j++) begin : g_cell
      ddc_fir_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (cell_ctrl),
         .mixed   (s2_mixed_ff),
         .coef    (FIR_COEF[j]),
         .sum_in  (sum_chain[j+1]),
         .sum_out (sum_chain[j])
      );
   end

   // ---------------------------------------------------------------------
   // gain: floor by 2^8 and wrap to 24 bits
   // ---------------------------------------------------------------------
   assign gain_prod_i = sum_chain[0].i * gain_ff;
   assign gain_prod_q = sum_chain[0].q * gain_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         g_out_ff.i <= gain_prod_i[GAIN_FRAC +: SAMPLE_WIDTH];
         g_out_ff.q <= gain_prod_q[GAIN_FRAC +: SAMPLE_WIDTH];
      end
   end

   // ---------------------------------------------------------------------
   // output register: loads only words that carry a result
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (adv && g_valid_ff && g_produce_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && g_valid_ff && g_produce_ff) begin
         rsp_data_ff <= g_out_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.i_sample = rsp_data_ff.i;
   assign rsp_chan.q_sample = rsp_data_ff.q;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `DDC_ASSERT_IMPLY(a_ready_low_cause, clock, reset, !req_chan.ready, g_valid_ff && g_produce_ff && rsp_valid_ff, "ready low without a waiting result")
   `DDC_ASSERT_IMPLY(a_rsp_from_gain, clock, reset, $rose(rsp_valid_ff), $past(adv && g_valid_ff && g_produce_ff), "result word not from the gain stage")
   `DDC_ASSERT_NEXT(a_phase_hold, clock, reset, !accept, $stable(phase_ff), "nco phase moved without a word")

endmodule
